// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the calculator, used by the back end (rsc_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ----- hw/rtl/rsc_pkg.sv -----
// Shared types, codes and defaults of the RPN stack calculator.
package rsc_pkg;

   localparam int STACK_DEPTH_DEF    = 128;
   localparam int VARIABLE_COUNT_DEF = 26;
   localparam int FRACTION_BITS_DEF  = 32;

   // token codes
   localparam logic [3:0] OP_NUMBER = 4'd0;
   localparam logic [3:0] OP_LETTER = 4'd1;
   localparam logic [3:0] OP_ADD    = 4'd2;
   localparam logic [3:0] OP_SUB    = 4'd3;
   localparam logic [3:0] OP_MUL    = 4'd4;
   localparam logic [3:0] OP_DIV    = 4'd5;
   localparam logic [3:0] OP_MOD    = 4'd6;
   localparam logic [3:0] OP_ASSIGN = 4'd7;
   localparam logic [3:0] OP_LAST   = 4'd8;
   localparam logic [3:0] OP_PRINT  = 4'd9;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_BADIDX  = 3'd5;
   localparam logic [2:0] ST_SAT     = 3'd6;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [63:0] number_value;
      logic [4:0]         letter_index;
   } req_type;

   typedef struct packed {
      logic               printed;
      logic signed [63:0] print_value;
      logic [2:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      CLS_NUM, CLS_LET, CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV,
      CLS_MOD, CLS_ASG, CLS_LAST, CLS_PRINT, CLS_UNK
   } cls_type;

   // classified token handed from front to back
   typedef struct packed {
      cls_type     cls;
      logic [63:0] number;
      logic [4:0]  letter;
      logic        letter_bad;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hw/rtl/rsc_front.sv -----
// Front end: accepts requests, classifies tokens, queues them for the back end.
module rsc_front #(
   parameter int VARIABLE_COUNT = rsc_pkg::VARIABLE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rsc_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output rsc_pkg::cmd_type cmd_data
);

   rsc_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   rsc_pkg::cmd_type cls_cmd;
   logic             do_push, do_pop;

   // token classification
   always_comb begin
      cls_cmd.number     = req_data.number_value;
      cls_cmd.letter     = req_data.letter_index;
      cls_cmd.letter_bad = (req_data.letter_index >= 5'(VARIABLE_COUNT));
      unique case (req_data.op)
         rsc_pkg::OP_NUMBER: cls_cmd.cls = rsc_pkg::CLS_NUM;
         rsc_pkg::OP_LETTER: cls_cmd.cls = rsc_pkg::CLS_LET;
         rsc_pkg::OP_ADD:    cls_cmd.cls = rsc_pkg::CLS_ADD;
         rsc_pkg::OP_SUB:    cls_cmd.cls = rsc_pkg::CLS_SUB;
         rsc_pkg::OP_MUL:    cls_cmd.cls = rsc_pkg::CLS_MUL;
         rsc_pkg::OP_DIV:    cls_cmd.cls = rsc_pkg::CLS_DIV;
         rsc_pkg::OP_MOD:    cls_cmd.cls = rsc_pkg::CLS_MOD;
         rsc_pkg::OP_ASSIGN: cls_cmd.cls = rsc_pkg::CLS_ASG;
         rsc_pkg::OP_LAST:   cls_cmd.cls = rsc_pkg::CLS_LAST;
         rsc_pkg::OP_PRINT:  cls_cmd.cls = rsc_pkg::CLS_PRINT;
         default:            cls_cmd.cls = rsc_pkg::CLS_UNK;
      endcase
   end

   // two-entry queue control
   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= cls_cmd;
      end
   end

endmodule

// ----- hw/rtl/rsc_divider.sv -----
// Radix-2 restoring divider, 64 iterations, shared by divide and remainder.
module rsc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           dividend_hi,
   input  logic [63:0]           dividend_lo,
   input  logic [63:0]           divisor,
   output rsc_pkg::div_stat_type stat,
   output logic [63:0]           quotient,
   output logic [63:0]           remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] d_ff, d_in;
   logic [63:0] shifted;
   logic        take;

   // one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff[62:0], lo_ff[63]};
      take    = rem_ff[63] || (shifted >= d_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = dividend_hi;
         lo_in   = dividend_lo;
         q_in    = 64'd0;
         d_in    = divisor;
      end else if (busy_ff) begin
         rem_in = take ? (shifted - d_ff) : shifted;
         lo_in  = {lo_ff[62:0], 1'b0};
         q_in   = {q_ff[62:0], take};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/rsc_back.sv -----
// Back end: operand stack, variables, arithmetic sequencer and status.
`include "assert_macros.svh"

module rsc_back #(
   parameter int STACK_DEPTH    = rsc_pkg::STACK_DEPTH_DEF,
   parameter int VARIABLE_COUNT = rsc_pkg::VARIABLE_COUNT_DEF,
   parameter int FRACTION_BITS  = rsc_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  rsc_pkg::cmd_type cmd_data,
   output logic             rsp_push,
   input  logic             rsp_full,
   output rsc_pkg::rsp_type rsp_data
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int VIW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
   localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_READ_Y = 7'b0000010,
      S_READ_X = 7'b0000100,
      S_EXEC   = 7'b0001000,
      S_MUL    = 7'b0010000,
      S_DIV    = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   // {saturated, value}
   function automatic logic [64:0] signed_result(logic [63:0] mag, logic neg,
                                                 logic too_big);
      logic [64:0] res;
      if (too_big) begin
         res = {1'b1, neg ? SIGN_BIT : MAX_POS};
      end else if (neg) begin
         res = (mag > SIGN_BIT) ? {1'b1, SIGN_BIT} : {1'b0, 64'd0 - mag};
      end else begin
         res = (mag > MAX_POS) ? {1'b1, MAX_POS} : {1'b0, mag};
      end
      return res;
   endfunction

   function automatic logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   rsc_pkg::cmd_type cmd_ff, cmd_in;
   logic [63:0]      y_ff, y_in, x_ff, x_in;
   logic             ypop_ff, ypop_in, xpop_ff, xpop_in;
   logic             empty_ff, empty_in, dz_ff, dz_in, bad_ff, bad_in;
   logic             sat_ff, sat_in, unk_ff, unk_in;
   logic             push_ff, push_in;
   logic [63:0]      pv_ff, pv_in;
   logic             printed_ff, printed_in;
   logic [63:0]      pval_ff, pval_in;
   logic [63:0]      last_ff, last_in;
   logic [63:0]      ma_ff, ma_in, mb_ff, mb_in;
   logic             neg_ff, neg_in;
   logic [127:0]     acc_ff, acc_in;
   logic [63:0]      prod_ff, prod_in;
   logic [1:0]       shift_ff, shift_in;
   logic [2:0]       step_ff, step_in;

   logic [63:0]      stack_mem [STACK_DEPTH];
   logic [63:0]      rd_data_ff;
   logic [CW-1:0]    top_wide;
   logic [AW-1:0]    top_addr;
   logic             mem_we;

   logic [63:0]      var_vals [VARIABLE_COUNT];
   logic [VARIABLE_COUNT-1:0] used_ff, used_in;
   logic             var_we;
   logic [VIW-1:0]   var_wa;

   logic             div_start;
   logic [63:0]      div_hi, div_lo, div_d;
   rsc_pkg::div_stat_type div_stat;
   logic [63:0]      div_q, div_rem;

   logic [63:0]      y_val, sum, diff, mag_x, mag_y, whole;
   logic [127:0]     wide_x, prod_shifted, acc_shifted;
   logic [64:0]      sres;
   logic [31:0]      a_sel, b_sel;
   logic [VIW-1:0]   let_idx;
   logic             full_ev, has_item;
   logic [2:0]       status;

   assign top_wide = count_ff - CW'(1);
   assign top_addr = top_wide[AW-1:0];
   assign has_item = (count_ff != '0);
   assign let_idx  = cmd_data.letter[VIW-1:0];
   assign mag_x    = magnitude(x_ff);
   assign mag_y    = magnitude(y_ff);
   assign wide_x   = {64'd0, mag_x} << FRACTION_BITS;
   assign whole    = mag_x >> FRACTION_BITS;
   assign sum      = x_ff + y_ff;
   assign diff     = x_ff - y_ff;
   assign y_val    = ypop_ff ? rd_data_ff : 64'd0;
   assign a_sel    = step_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_sel    = step_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
   assign full_ev  = push_ff && (count_ff == CW'(STACK_DEPTH));
   assign acc_shifted = acc_ff >> FRACTION_BITS;

   // partial product alignment
   always_comb begin
      case (shift_ff)
         2'd0:    prod_shifted = {64'd0, prod_ff};
         2'd1:    prod_shifted = {32'd0, prod_ff, 32'd0};
         default: prod_shifted = {prod_ff, 64'd0};
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      y_in       = y_ff;
      x_in       = x_ff;
      ypop_in    = ypop_ff;
      xpop_in    = xpop_ff;
      empty_in   = empty_ff;
      dz_in      = dz_ff;
      bad_in     = bad_ff;
      sat_in     = sat_ff;
      unk_in     = unk_ff;
      push_in    = push_ff;
      pv_in      = pv_ff;
      printed_in = printed_ff;
      pval_in    = pval_ff;
      last_in    = last_ff;
      ma_in      = ma_ff;
      mb_in      = mb_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      shift_in   = shift_ff;
      step_in    = step_ff;
      used_in    = used_ff;
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      var_we     = 1'b0;
      var_wa     = whole[VIW-1:0];
      div_start  = 1'b0;
      div_hi     = wide_x[127:64];
      div_lo     = wide_x[63:0];
      div_d      = mag_y;
      rsp_push   = 1'b0;
      sres       = signed_result(64'd0, 1'b0, 1'b0);
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               cmd_in     = cmd_data;
               empty_in   = 1'b0;
               dz_in      = 1'b0;
               bad_in     = 1'b0;
               sat_in     = 1'b0;
               unk_in     = 1'b0;
               push_in    = 1'b0;
               printed_in = 1'b0;
               pval_in    = 64'd0;
               state_in   = S_FINISH;
               case (cmd_data.cls) inside
                  rsc_pkg::CLS_NUM: begin
                     push_in = 1'b1;
                     pv_in   = cmd_data.number;
                  end
                  rsc_pkg::CLS_LET: begin
                     if (cmd_data.letter_bad) begin
                        bad_in = 1'b1;
                     end else begin
                        push_in = 1'b1;
                        pv_in   = used_ff[let_idx] ? var_vals[let_idx]
                                                   : (64'(cmd_data.letter) << FRACTION_BITS);
                     end
                  end
                  rsc_pkg::CLS_LAST: begin
                     push_in = 1'b1;
                     pv_in   = last_ff;
                  end
                  rsc_pkg::CLS_ADD, rsc_pkg::CLS_SUB, rsc_pkg::CLS_MUL, rsc_pkg::CLS_DIV,
                  rsc_pkg::CLS_MOD, rsc_pkg::CLS_ASG, rsc_pkg::CLS_PRINT: begin
                     // pop the second operand; memory data comes next cycle
                     ypop_in  = has_item;
                     empty_in = !has_item;
                     if (has_item) begin
                        count_in = top_wide;
                     end
                     state_in = S_READ_Y;
                  end
                  default: unk_in = 1'b1;
               endcase
            end
         end
         S_READ_Y: begin
            y_in = y_val;
            if (cmd_ff.cls == rsc_pkg::CLS_PRINT) begin
               last_in    = y_val;
               printed_in = !empty_ff;
               pval_in    = empty_ff ? 64'd0 : y_val;
               state_in   = S_FINISH;
            end else if ((cmd_ff.cls == rsc_pkg::CLS_DIV || cmd_ff.cls == rsc_pkg::CLS_MOD)
                         && y_val == 64'd0) begin
               dz_in    = 1'b1;
               state_in = S_FINISH;
            end else begin
               xpop_in  = has_item;
               empty_in = empty_ff || !has_item;
               if (has_item) begin
                  count_in = top_wide;
               end
               state_in = S_READ_X;
            end
         end
         S_READ_X: begin
            x_in     = xpop_ff ? rd_data_ff : 64'd0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FINISH;
            neg_in   = x_ff[63] ^ y_ff[63];
            case (cmd_ff.cls)
               rsc_pkg::CLS_ADD: begin
                  push_in = 1'b1;
                  if (!(x_ff[63] ^ y_ff[63]) && (sum[63] ^ x_ff[63])) begin
                     sat_in = 1'b1;
                     pv_in  = x_ff[63] ? SIGN_BIT : MAX_POS;
                  end else begin
                     pv_in = sum;
                  end
               end
               rsc_pkg::CLS_SUB: begin
                  push_in = 1'b1;
                  if ((x_ff[63] ^ y_ff[63]) && (diff[63] ^ x_ff[63])) begin
                     sat_in = 1'b1;
                     pv_in  = x_ff[63] ? SIGN_BIT : MAX_POS;
                  end else begin
                     pv_in = diff;
                  end
               end
               rsc_pkg::CLS_MUL: begin
                  ma_in    = mag_x;
                  mb_in    = mag_y;
                  acc_in   = 128'd0;
                  step_in  = 3'd0;
                  state_in = S_MUL;
               end
               rsc_pkg::CLS_DIV: begin
                  if (div_hi >= div_d) begin
                     push_in = 1'b1;
                     sat_in  = 1'b1;
                     pv_in   = neg_in ? SIGN_BIT : MAX_POS;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               rsc_pkg::CLS_MOD: begin
                  div_hi    = 64'd0;
                  div_lo    = mag_x;
                  div_start = 1'b1;
                  neg_in    = x_ff[63];
                  state_in  = S_DIV;
               end
               rsc_pkg::CLS_ASG: begin
                  push_in = 1'b1;
                  pv_in   = y_ff;
                  if ((x_ff[63] && whole != 64'd0) || whole >= 64'(VARIABLE_COUNT)) begin
                     bad_in = 1'b1;
                  end else begin
                     var_we          = 1'b1;
                     used_in[var_wa] = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_MUL: begin
            // multiply in steps 0..3, accumulate in steps 1..4, result in 5
            step_in = step_ff + 3'd1;
            if (step_ff < 3'd4) begin
               prod_in  = 64'(a_sel) * 64'(b_sel);
               shift_in = {1'b0, step_ff[0]} + {1'b0, step_ff[1]};
            end
            if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
               acc_in = acc_ff + prod_shifted;
            end
            if (step_ff == 3'd5) begin
               sres     = signed_result(acc_shifted[63:0], neg_ff, |acc_shifted[127:64]);
               push_in  = 1'b1;
               sat_in   = sres[64];
               pv_in    = sres[63:0];
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               push_in = 1'b1;
               if (cmd_ff.cls == rsc_pkg::CLS_MOD) begin
                  pv_in = neg_ff ? (64'd0 - div_rem) : div_rem;
               end else begin
                  sres   = signed_result(div_q, neg_ff, 1'b0);
                  sat_in = sres[64];
                  pv_in  = sres[63:0];
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (push_ff && !full_ev) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // status priority
   always_comb begin
      if (unk_ff)        status = rsc_pkg::ST_UNKNOWN;
      else if (dz_ff)    status = rsc_pkg::ST_DIVZERO;
      else if (bad_ff)   status = rsc_pkg::ST_BADIDX;
      else if (sat_ff)   status = rsc_pkg::ST_SAT;
      else if (full_ev)  status = rsc_pkg::ST_FULL;
      else if (empty_ff) status = rsc_pkg::ST_EMPTY;
      else               status = rsc_pkg::ST_OK;
   end

   assign rsp_data.printed     = printed_ff;
   assign rsp_data.print_value = pval_ff;
   assign rsp_data.status      = status;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         used_ff  <= '0;
         last_ff  <= 64'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff  <= used_in;
         last_ff  <= last_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      y_ff       <= y_in;
      x_ff       <= x_in;
      ypop_ff    <= ypop_in;
      xpop_ff    <= xpop_in;
      empty_ff   <= empty_in;
      dz_ff      <= dz_in;
      bad_ff     <= bad_in;
      sat_ff     <= sat_in;
      unk_ff     <= unk_in;
      push_ff    <= push_in;
      pv_ff      <= pv_in;
      printed_ff <= printed_in;
      pval_ff    <= pval_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      shift_ff   <= shift_in;
      step_ff    <= step_in;
   end

   // operand stack memory: one write, one registered read at top of stack
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[count_ff[AW-1:0]] <= pv_ff;
      end
      rd_data_ff <= stack_mem[top_addr];
   end

   // variable registers
   always_ff @(posedge clock) begin
      if (var_we) begin
         var_vals[var_wa] <= y_ff;
      end
   end

   rsc_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend_hi (div_hi),
      .dividend_lo (div_lo),
      .divisor     (div_d),
      .stat        (div_stat),
      .quotient    (div_q),
      .remainder   (div_rem)
   );

   `ASSERT_CLK(a_count_range, clock, reset, count_ff <= CW'(STACK_DEPTH))
   `ASSERT_CLK(a_div_wait, clock, reset, div_start |=> (state_ff == S_DIV) && div_stat.busy)
   `ASSERT_CLK(a_one_rsp, clock, reset, rsp_push |=> (state_ff == S_IDLE) && !rsp_push)
   `ASSERT_NEVER(a_push_full, clock, reset, rsp_push && rsp_full)

endmodule

// ----- hw/rtl/rsc_rsp_queue.sv -----
// Two-entry result queue between the back end and the result ports.
module rsc_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   output logic             in_full,
   input  rsc_pkg::rsp_type in_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsc_pkg::rsp_type rsp_data
);

   rsc_pkg::rsp_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign in_full   = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign do_push   = in_push && !in_full;
   assign do_pop    = rsp_pop && !rsp_empty;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- hw/rtl/rpn_stack_calculator_with_vars.sv -----
// Top level of the RPN stack calculator with variables.
//
// Requests enter as queue pushes: req_data carries one token (op, Q32.32
// literal, letter) and is taken when req_push is high and req_full is low.
// Every request gives exactly one result, in order, on rsp_data while
// rsp_empty is low; rsp_pop takes it.
// Items are worked one at a time by the back end after a two-entry front
// queue; the back end takes the next item once it has handed its result on.
// Number, letter, last and unknown tokens go straight to the result; print
// reads one operand; add, sub and assign read two and execute; mul uses
// one 32x32 multiplier over four partial products; div and mod use the
// 64-iteration radix-2 divider (skipped on a zero divisor or early div saturation).
// Stack pops read the operand stack memory through its registered port,
// one operand a cycle.
// Reset clears the stack count, variable used flags and last printed
// value; no memory sweep is needed. When the receiver stalls, results pile
// up in the two-entry result queue, then the back end holds its finished
// item and the front queue fills until req_full rises.
module rpn_stack_calculator_with_vars #(
   parameter int STACK_DEPTH    = rsc_pkg::STACK_DEPTH_DEF,
   parameter int VARIABLE_COUNT = rsc_pkg::VARIABLE_COUNT_DEF,
   parameter int FRACTION_BITS  = rsc_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rsc_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsc_pkg::rsp_type rsp_data
);

   logic             cmd_valid, cmd_pop;
   rsc_pkg::cmd_type cmd_data;
   logic             res_push, res_full;
   rsc_pkg::rsp_type res_data;

   rsc_front #(
      .VARIABLE_COUNT (VARIABLE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   rsc_back #(
      .STACK_DEPTH    (STACK_DEPTH),
      .VARIABLE_COUNT (VARIABLE_COUNT),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_push  (res_push),
      .rsp_full  (res_full),
      .rsp_data  (res_data)
   );

   rsc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (res_push),
      .in_full   (res_full),
      .in_data   (res_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
